// ===== rtl/ipfd_pkg.sv =====
// Shared types and constants for the IR pulse frame decoder.
// Used by every module under rtl; depends on nothing else.
package ipfd_pkg;

	// Interval and window widths
	localparam int IntervalW = 16;
	localparam int FrameBits = 16;
	localparam int NibbleW   = 4;

	// Configuration register indexes
	localparam int CfgIndexW = 3;
	localparam logic [CfgIndexW-1:0] CFG_START_MIN = 3'd0;
	localparam logic [CfgIndexW-1:0] CFG_START_MAX = 3'd1;
	localparam logic [CfgIndexW-1:0] CFG_ONE_MIN   = 3'd2;
	localparam logic [CfgIndexW-1:0] CFG_ONE_MAX   = 3'd3;
	localparam logic [CfgIndexW-1:0] CFG_ZERO_MIN  = 3'd4;
	localparam logic [CfgIndexW-1:0] CFG_ZERO_MAX  = 3'd5;

	// Register reset values, microseconds
	localparam logic [IntervalW-1:0] RST_START_MIN = 16'd948;
	localparam logic [IntervalW-1:0] RST_START_MAX = 16'd1579;
	localparam logic [IntervalW-1:0] RST_ONE_MIN   = 16'd527;
	localparam logic [IntervalW-1:0] RST_ONE_MAX   = 16'd947;
	localparam logic [IntervalW-1:0] RST_ZERO_MIN  = 16'd316;
	localparam logic [IntervalW-1:0] RST_ZERO_MAX  = 16'd526;

	// Bit class of one interval, as seen inside a frame
	localparam logic [1:0] BIT_ZERO = 2'd0;
	localparam logic [1:0] BIT_ONE  = 2'd1;
	localparam logic [1:0] BIT_BAD  = 2'd2;

	// Result status codes
	localparam int StatusW = 2;
	localparam logic [StatusW-1:0] STATUS_GOOD     = 2'd0;
	localparam logic [StatusW-1:0] STATUS_CHECKSUM = 2'd1;
	localparam logic [StatusW-1:0] STATUS_BADBIT   = 2'd2;

	localparam logic [NibbleW-1:0] CHECK_SEED = 4'hF;

	// Queue between classifier and frame engine
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// One classified interval
	typedef struct packed {
		logic       is_start;
		logic [1:0] bit_cls;
	} cls_item_t;

	// Queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/ipfd_front.sv =====
// Front end: holds the window registers and classifies each input interval.
// Depends on ipfd_pkg.
module ipfd_front import ipfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [IntervalW-1:0] cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IntervalW-1:0] s_tdata,
	input  q_stat_t              q_stat,
	output logic                 push,
	output cls_item_t            push_item
);

	logic [IntervalW-1:0] start_min_q, start_max_q;
	logic [IntervalW-1:0] one_min_q, one_max_q;
	logic [IntervalW-1:0] zero_min_q, zero_max_q;
	logic                 hit_start, hit_one, hit_zero;

	// Window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_min_q <= RST_START_MIN;
			start_max_q <= RST_START_MAX;
			one_min_q   <= RST_ONE_MIN;
			one_max_q   <= RST_ONE_MAX;
			zero_min_q  <= RST_ZERO_MIN;
			zero_max_q  <= RST_ZERO_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MIN: start_min_q <= cfg_wdata;
				CFG_START_MAX: start_max_q <= cfg_wdata;
				CFG_ONE_MIN:   one_min_q   <= cfg_wdata;
				CFG_ONE_MAX:   one_max_q   <= cfg_wdata;
				CFG_ZERO_MIN:  zero_min_q  <= cfg_wdata;
				CFG_ZERO_MAX:  zero_max_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Inclusive window tests; one wins over zero
	assign hit_start = (s_tdata >= start_min_q) && (s_tdata <= start_max_q);
	assign hit_one   = (s_tdata >= one_min_q)   && (s_tdata <= one_max_q);
	assign hit_zero  = (s_tdata >= zero_min_q)  && (s_tdata <= zero_max_q);

	always_comb begin
		push_item.is_start = hit_start;
		if (hit_one) begin
			push_item.bit_cls = BIT_ONE;
		end else if (hit_zero) begin
			push_item.bit_cls = BIT_ZERO;
		end else begin
			push_item.bit_cls = BIT_BAD;
		end
	end

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

endmodule

// ===== rtl/ipfd_queue.sv =====
// Short queue of classified intervals between front end and frame engine.
// Depends on ipfd_pkg.
module ipfd_queue import ipfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t push_item,
	input  logic      pop,
	output cls_item_t pop_item,
	output q_stat_t   q_stat
);

	cls_item_t        entry_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			if (push && !pop) begin
				count_q <= count_q + QCntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

	assign pop_item     = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCntW'(QDepth));
	assign q_stat.empty = (count_q == '0);

endmodule

// ===== rtl/ipfd_back.sv =====
// Back end: frame engine that turns classified intervals into frame results,
// with a result register toward the output channel. Depends on ipfd_pkg.
module ipfd_back import ipfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  q_stat_t            q_stat,
	input  cls_item_t          pop_item,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,
	output logic [StatusW-1:0] m_tuser
);

	localparam int CntW = $clog2(FrameBits);

	logic                 in_frame_q;
	logic [CntW-1:0]      bit_count_q;
	logic [FrameBits-1:0] shift_q;
	logic                 out_valid_q;
	logic [NibbleW-1:0]   nib_a_q, nib_b_q, nib_c_q;
	logic [StatusW-1:0]   status_q;

	logic                 shift_in;
	logic [FrameBits-1:0] shift_next;
	logic                 last_bit;
	logic [NibbleW-1:0]   na, nb, nc, nd;

	// Pop whenever the result register is free or being drained
	assign pop = !q_stat.empty && (!out_valid_q || m_tready);

	assign shift_in   = (pop_item.bit_cls == BIT_ONE);
	assign shift_next = {shift_q[FrameBits-2:0], shift_in};
	assign last_bit   = (bit_count_q == CntW'(FrameBits - 1));
	assign na = shift_next[15:12];
	assign nb = shift_next[11:8];
	assign nc = shift_next[7:4];
	assign nd = shift_next[3:0];

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			bit_count_q <= '0;
			shift_q     <= '0;
		end else if (pop) begin
			if (!in_frame_q) begin
				if (pop_item.is_start) begin
					in_frame_q  <= 1'b1;
					bit_count_q <= '0;
					shift_q     <= '0;
				end
			end else if (pop_item.bit_cls == BIT_BAD) begin
				in_frame_q  <= 1'b0;
				bit_count_q <= '0;
			end else begin
				shift_q     <= shift_next;
				bit_count_q <= bit_count_q + CntW'(1);
				if (last_bit) in_frame_q <= 1'b0;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && in_frame_q && (pop_item.bit_cls == BIT_BAD || last_bit)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && in_frame_q) begin
			if (pop_item.bit_cls == BIT_BAD) begin
				nib_a_q  <= '0;
				nib_b_q  <= '0;
				nib_c_q  <= '0;
				status_q <= STATUS_BADBIT;
			end else if (last_bit) begin
				nib_a_q  <= na;
				nib_b_q  <= nb;
				nib_c_q  <= nc;
				status_q <= ((CHECK_SEED ^ na ^ nb ^ nc) == nd) ? STATUS_GOOD
				                                                 : STATUS_CHECKSUM;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, nib_c_q, nib_b_q, nib_a_q};
	assign m_tuser  = status_q;

endmodule

// ===== rtl/ir_pulse_frame_decoder.sv =====
// Top level of the IR pulse frame decoder: classifier, queue, frame engine.
// Depends on ipfd_pkg, ipfd_front, ipfd_queue and ipfd_back.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata = interval_us
//  m_        out        m_tvalid / m_tready  m_tdata = nibbles, m_tuser = status
//  cfg_      in         cfg_we               cfg_index, cfg_wdata (window registers)
//
// One interval is taken per cycle while s_tready is high; each is classified
// against the windows in the cycle it is taken, then queued (four deep) for the
// frame engine, which retires one per cycle while the result register is free or
// drained. A result appears the cycle after its last interval leaves the queue
// and sits in the result register until taken; a stalled output fills the queue,
// then drops s_tready. Reset clears the frame state and loads the default windows.
module ir_pulse_frame_decoder import ipfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [15:0] interval_us
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [3:0] nibble_a, [7:4] nibble_b, [11:8] nibble_c
	output logic [1:0]           m_tuser,   // [1:0] status
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [15:0]          cfg_wdata
);

	logic      push, pop;
	cls_item_t push_item, pop_item;
	q_stat_t   q_stat;

	ipfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	ipfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	ipfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_item (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== rtl/ipfd_checker.sv =====
// Port-level checks for the IR pulse frame decoder, bound to the top level.
// Depends on ipfd_pkg.
module ipfd_checker import ipfd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Status is never the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STATUS_GOOD || m_tuser == STATUS_CHECKSUM ||
		              m_tuser == STATUS_BADBIT))
		else $error("unused status code");

	// A bad-bit result carries zero nibbles
	a_badbit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_BADBIT |-> m_tdata == 16'h0000)
		else $error("bad-bit result with nonzero nibbles");

	// Padding bits of a result are zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:12] == 4'h0)
		else $error("result padding not zero");

endmodule

bind ir_pulse_frame_decoder ipfd_checker u_ipfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
